[hw/rtl/biou_pkg.sv]
// Shared constants and types for the box IoU match-cost block.
// No dependencies; imported by every module of the block.
`default_nettype none

package biou_pkg;

  // Field widths fixed by the word format.
  localparam int COORD_W   = 14;
  localparam int SIZE_IN_W = 12;
  localparam int AGE_W     = 8;

  // Defaults for the top-level parameters.
  localparam int SIZE_BITS_DEF = 12;
  localparam int COST_FRAC_DEF = 16;

  // Reset value of the stale age limit.
  localparam logic [AGE_W-1:0] STALE_LIMIT_RST = AGE_W'(1);

  // Flags that ride along with a pair through the pipeline.
  typedef struct packed {
    logic stale;       // track older than the limit
    logic zero_union;  // both boxes have zero area
  } biou_flags_t;

endpackage

`default_nettype wire

[hw/rtl/biou_front.sv]
// Geometry front end: overlap per axis, three areas and the union, in four stages.
// Depends on biou_pkg.
`default_nettype none

module biou_front
  import biou_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [COORD_W-1:0]     track_left,
  input  wire logic [COORD_W-1:0]     track_top,
  input  wire logic [SIZE_IN_W-1:0]   track_width,
  input  wire logic [SIZE_IN_W-1:0]   track_height,
  input  wire logic [COORD_W-1:0]     det_left,
  input  wire logic [COORD_W-1:0]     det_top,
  input  wire logic [SIZE_IN_W-1:0]   det_width,
  input  wire logic [SIZE_IN_W-1:0]   det_height,
  input  wire logic                   stale,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [2*((SIZE_BITS < SIZE_IN_W) ? SIZE_BITS : SIZE_IN_W):0] union_area,
  output logic [2*((SIZE_BITS < SIZE_IN_W) ? SIZE_BITS : SIZE_IN_W):0] rem_init,
  output logic                        bring_bit,
  output biou_flags_t                 flags
);

  // Only the low size bits of each width and height take part.
  localparam int SW = (SIZE_BITS < SIZE_IN_W) ? SIZE_BITS : SIZE_IN_W;
  localparam int EW = COORD_W + 1;
  localparam int AW = 2 * SW;
  localparam int UW = AW + 1;

  logic v1_r, v2_r, v3_r, v4_r;
  logic r1, r2, r3, r4;

  assign r4       = !v4_r || out_ready;
  assign r3       = !v3_r || r4;
  assign r2       = !v2_r || r3;
  assign r1       = !v1_r || r2;
  assign in_ready = r1;

  // Stage 1: interval ends on each axis.
  logic signed [EW-1:0] tl_s, tt_s, dl_s, dt_s, tr_s, tb_s, dr_s, db_s;
  logic signed [EW-1:0] xlo_nxt, xhi_nxt, ylo_nxt, yhi_nxt;
  logic signed [EW-1:0] xlo_r, xhi_r, ylo_r, yhi_r;
  logic [SW-1:0]        tw1_r, th1_r, dw1_r, dh1_r;
  logic                 stale1_r;

  always_comb begin
    tl_s = $signed({track_left[COORD_W-1], track_left});
    tt_s = $signed({track_top[COORD_W-1], track_top});
    dl_s = $signed({det_left[COORD_W-1], det_left});
    dt_s = $signed({det_top[COORD_W-1], det_top});
    tr_s = tl_s + $signed({{(EW-SW){1'b0}}, track_width[SW-1:0]});
    tb_s = tt_s + $signed({{(EW-SW){1'b0}}, track_height[SW-1:0]});
    dr_s = dl_s + $signed({{(EW-SW){1'b0}}, det_width[SW-1:0]});
    db_s = dt_s + $signed({{(EW-SW){1'b0}}, det_height[SW-1:0]});
    xlo_nxt = (tl_s > dl_s) ? tl_s : dl_s;
    xhi_nxt = (tr_s < dr_s) ? tr_s : dr_s;
    ylo_nxt = (tt_s > dt_s) ? tt_s : dt_s;
    yhi_nxt = (tb_s < db_s) ? tb_s : db_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (r1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && r1) begin
      xlo_r    <= xlo_nxt;
      xhi_r    <= xhi_nxt;
      ylo_r    <= ylo_nxt;
      yhi_r    <= yhi_nxt;
      tw1_r    <= track_width[SW-1:0];
      th1_r    <= track_height[SW-1:0];
      dw1_r    <= det_width[SW-1:0];
      dh1_r    <= det_height[SW-1:0];
      stale1_r <= stale;
    end
  end

  // Stage 2: overlap lengths, clamped at zero. An overlap never exceeds
  // the narrower box, so it fits the size width.
  logic signed [EW-1:0] xd, yd;
  logic [SW-1:0]        ox_nxt, oy_nxt, ox_r, oy_r;
  logic [SW-1:0]        tw2_r, th2_r, dw2_r, dh2_r;
  logic                 stale2_r;

  always_comb begin
    xd     = xhi_r - xlo_r;
    yd     = yhi_r - ylo_r;
    ox_nxt = (xhi_r > xlo_r) ? xd[SW-1:0] : '0;
    oy_nxt = (yhi_r > ylo_r) ? yd[SW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (r2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r && r2) begin
      ox_r     <= ox_nxt;
      oy_r     <= oy_nxt;
      tw2_r    <= tw1_r;
      th2_r    <= th1_r;
      dw2_r    <= dw1_r;
      dh2_r    <= dh1_r;
      stale2_r <= stale1_r;
    end
  end

  // Stage 3: intersection and the two box areas.
  logic [AW-1:0] inter_r, area_t_r, area_d_r;
  logic          stale3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (r3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r && r3) begin
      inter_r  <= ox_r * oy_r;
      area_t_r <= tw2_r * th2_r;
      area_d_r <= dw2_r * dh2_r;
      stale3_r <= stale2_r;
    end
  end

  // Stage 4: union, and the first partial remainder of the division.
  // The dividend is inter shifted up by the fraction bits; the bits above
  // the quotient are inter >> 1, and inter[0] is brought down first.
  logic [UW-1:0] uni_nxt, uni_r, rem_r;
  logic          bring_r;
  biou_flags_t   flags_r;

  assign uni_nxt = {1'b0, area_t_r} + {1'b0, area_d_r} - {1'b0, inter_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (r4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v3_r && r4) begin
      uni_r              <= uni_nxt;
      rem_r              <= {2'b00, inter_r[AW-1:1]};
      bring_r            <= inter_r[0];
      flags_r.stale      <= stale3_r;
      flags_r.zero_union <= (uni_nxt == '0);
    end
  end

  assign out_valid  = v4_r;
  assign union_area = uni_r;
  assign rem_init   = rem_r;
  assign bring_bit  = bring_r;
  assign flags      = flags_r;

endmodule

`default_nettype wire

[hw/rtl/biou_div_cell.sv]
// One restoring-division cell: brings down a dividend bit and yields one quotient bit.
// Depends on biou_pkg.
`default_nettype none

module biou_div_cell
  import biou_pkg::*;
#(
  parameter int UW = 2 * SIZE_BITS_DEF + 1,
  parameter int QW = COST_FRAC_DEF + 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [UW-1:0] in_rem,
  input  wire logic          in_bring,
  input  wire logic [UW-1:0] in_uni,
  input  wire logic [QW-1:0] in_quot,
  input  wire biou_flags_t   in_flags,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [UW-1:0]      out_rem,
  output logic [UW-1:0]      out_uni,
  output logic [QW-1:0]      out_quot,
  output biou_flags_t        out_flags
);

  logic          valid_r;
  logic [UW:0]   trial;
  logic          take;
  logic [UW:0]   diff;
  logic [UW-1:0] rem_nxt, rem_r, uni_r;
  logic [QW-1:0] quot_r;
  biou_flags_t   flags_r;

  assign in_ready = !valid_r || out_ready;

  // Partial remainder stays below the divisor, so the difference fits.
  always_comb begin
    trial   = {in_rem, in_bring};
    take    = (trial >= {1'b0, in_uni});
    diff    = trial - {1'b0, in_uni};
    rem_nxt = take ? diff[UW-1:0] : trial[UW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rem_r   <= rem_nxt;
      uni_r   <= in_uni;
      quot_r  <= {in_quot[QW-2:0], take};
      flags_r <= in_flags;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_uni   = uni_r;
  assign out_quot  = quot_r;
  assign out_flags = flags_r;

endmodule

`default_nettype wire

[hw/rtl/box_iou_match_cost.sv]
// Box IoU matching cost: top level with stream ports, config register and divider chain.
// Depends on biou_pkg, biou_front and biou_div_cell.
//
// Usage: the host streams (track box, detection box, track age) words on the
// in_ stream channel and gets one cost word per input word on the out_
// channel, in the same order. The cost is one minus IoU in unsigned fixed
// point with COST_FRACTION_BITS fraction bits; a track whose age is above
// the stale age limit gets a cost of one with out_tuser set.
// The stale age limit is written on the cfg_ channel, which is always ready;
// write it only while no word is in flight.
// A word passes through four geometry stages, one divider cell per quotient
// bit (COST_FRACTION_BITS + 1 cells) and the output register. Throughput is
// one word per cycle while the receiver keeps out_tready high.
// Every stage holds its own valid bit, so a stalled receiver only fills the
// pipeline: words keep being accepted until all stages are full, and nothing
// is dropped or repeated. Reset clears all valid bits and sets the stale age
// limit to 1.
`default_nettype none

module box_iou_match_cost
  import biou_pkg::*;
#(
  parameter int SIZE_BITS          = SIZE_BITS_DEF,
  parameter int COST_FRACTION_BITS = COST_FRAC_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input words.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // From bit 0 up: track_left[14], track_top[14], track_width[12],
  // track_height[12], det_left[14], det_top[14], det_width[12],
  // det_height[12], frames_since_update[8].
  input  wire logic [111:0] in_tdata,
  // Result words.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // From bit 0 up: match_cost[COST_FRACTION_BITS+1], zero fill to a byte.
  output logic [((COST_FRACTION_BITS + 8) / 8) * 8 - 1:0] out_tdata,
  // Bit 0: cost_infinite.
  output logic             out_tuser,
  // Stale age limit writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [AGE_W-1:0] cfg_data
);

  localparam int SW    = (SIZE_BITS < SIZE_IN_W) ? SIZE_BITS : SIZE_IN_W;
  localparam int UW    = 2 * SW + 1;
  localparam int QW    = COST_FRACTION_BITS + 1;
  localparam int NCELL = QW;
  localparam int OW    = ((COST_FRACTION_BITS + 8) / 8) * 8;
  localparam logic [QW-1:0] COST_ONE = {1'b1, {COST_FRACTION_BITS{1'b0}}};

  // Configuration register.
  logic [AGE_W-1:0] stale_limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_limit_r <= STALE_LIMIT_RST;
    end else if (cfg_valid) begin
      stale_limit_r <= cfg_data;
    end
  end

  // Unpack the input word.
  logic [COORD_W-1:0]   track_left, track_top, det_left, det_top;
  logic [SIZE_IN_W-1:0] track_width, track_height, det_width, det_height;
  logic [AGE_W-1:0]     frames_since_update;
  logic                 stale_in;

  assign track_left          = in_tdata[13:0];
  assign track_top           = in_tdata[27:14];
  assign track_width         = in_tdata[39:28];
  assign track_height        = in_tdata[51:40];
  assign det_left            = in_tdata[65:52];
  assign det_top             = in_tdata[79:66];
  assign det_width           = in_tdata[91:80];
  assign det_height          = in_tdata[103:92];
  assign frames_since_update = in_tdata[111:104];
  assign stale_in            = (frames_since_update > stale_limit_r);

  // Links of the divider chain; link 0 comes from the front end.
  logic              lv   [NCELL+1];
  logic              lr   [NCELL+1];
  logic [UW-1:0]     lrem [NCELL+1];
  logic [UW-1:0]     luni [NCELL+1];
  logic [QW-1:0]     lquot[NCELL+1];
  biou_flags_t       lflg [NCELL+1];
  logic              bring0;

  assign lquot[0] = '0;

  biou_front #(
    .SIZE_BITS (SIZE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .track_left   (track_left),
    .track_top    (track_top),
    .track_width  (track_width),
    .track_height (track_height),
    .det_left     (det_left),
    .det_top      (det_top),
    .det_width    (det_width),
    .det_height   (det_height),
    .stale        (stale_in),
    .out_valid    (lv[0]),
    .out_ready    (lr[0]),
    .union_area   (luni[0]),
    .rem_init     (lrem[0]),
    .bring_bit    (bring0),
    .flags        (lflg[0])
  );

  // One cell per quotient bit, most significant first. Only the first cell
  // brings down a bit of the intersection (bit 0); the rest bring down zeros.
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    biou_div_cell #(
      .UW (UW),
      .QW (QW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (lv[k]),
      .in_ready  (lr[k]),
      .in_rem    (lrem[k]),
      .in_bring  ((k == 0) ? bring0 : 1'b0),
      .in_uni    (luni[k]),
      .in_quot   (lquot[k]),
      .in_flags  (lflg[k]),
      .out_valid (lv[k+1]),
      .out_ready (lr[k+1]),
      .out_rem   (lrem[k+1]),
      .out_uni   (luni[k+1]),
      .out_quot  (lquot[k+1]),
      .out_flags (lflg[k+1])
    );
  end

  // Output register. The quotient never exceeds one since the intersection
  // never exceeds the union; a zero union or a stale track gives full cost.
  logic          out_v_r;
  logic [QW-1:0] cost_r, cost_nxt;
  logic          inf_r;
  logic          out_load;

  assign lr[NCELL] = !out_v_r || out_tready;
  assign out_load  = lv[NCELL] && lr[NCELL];
  assign cost_nxt  = (lflg[NCELL].stale || lflg[NCELL].zero_union)
                     ? COST_ONE : (COST_ONE - lquot[NCELL]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (lr[NCELL]) begin
      out_v_r <= lv[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cost_r <= cost_nxt;
      inf_r  <= lflg[NCELL].stale;
    end
  end

  // lrem of the last cell is the final remainder and is not needed.
  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OW-QW){1'b0}}, cost_r};
  assign out_tuser  = inf_r;

endmodule

`default_nettype wire
